// ----- hw/rtl/arp_single_entry_resolver_defines.svh -----
// ----------------------------------------------------------------------------
// ARP single-entry resolver assertion macros
// These macros give the concurrent checks of the resolver one common form.
// ----------------------------------------------------------------------------
`ifndef ARP_SINGLE_ENTRY_RESOLVER_DEFINES_SVH
`define ARP_SINGLE_ENTRY_RESOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpr: next-cycle check failed");

`endif

// ----- hw/rtl/arpr_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP single-entry resolver package
// Payload types, entry states and protocol constants of the resolver.
// ----------------------------------------------------------------------------
package arpr_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_RX      = 2'd1;
   localparam logic [1:0] OP_RESOLVE = 2'd2;

   localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
   localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

   localparam int          CSR_ADDR_W = 6;
   localparam logic [2:0]  REG_OWN_MAC       = 3'd0;
   localparam logic [2:0]  REG_OWN_IP        = 3'd1;
   localparam logic [2:0]  REG_VALID_TICKS   = 3'd2;
   localparam logic [2:0]  REG_PENDING_TICKS = 3'd3;
   localparam logic [2:0]  REG_MAX_RETRIES   = 3'd4;

   localparam logic [15:0] VALID_TICKS_RST   = 16'd5;
   localparam logic [15:0] PENDING_TICKS_RST = 16'd1;
   localparam logic [7:0]  MAX_RETRIES_RST   = 8'd4;

   typedef enum logic [1:0] {
      ENTRY_FREE    = 2'd0,
      ENTRY_VALID   = 2'd1,
      ENTRY_PENDING = 2'd2
   } entry_state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        frame_long_enough;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] arp_op;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] tgt_ip;
      logic [31:0] query_ip;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic        send_is_reply;
      logic [47:0] dest_mac;
      logic [47:0] out_target_mac;
      logic [31:0] out_tgt_ip;
      logic        resolve_hit;
      logic [47:0] resolved_mac;
      logic [1:0]  entry_status;
   } rsp_type;

endpackage

// ----- hw/rtl/arp_single_entry_resolver.sv -----
// ----------------------------------------------------------------------------
// ARP single-entry resolver
// Holds one ARP cache entry with aging and retry, answers requests addressed
// to this host and resolves IPv4 addresses against the entry.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req channel as tick, received ARP header or resolve
// query, selected by opcode. Every item yields exactly one transfer on the
// rsp channel, in order, carrying any packet to send, the resolve outcome and
// the entry status after the item.
// An accepted item is held in an input register; once the result register is
// free or being read, a single pass of compare and decrement logic updates
// the entry and loads the result register. One item per cycle is sustained
// while the receiver does not stall.
// When the receiver stalls, the result register holds its transfer, the next
// item waits in the input register, and req_ready falls once both are full.
// Registers are written through the APB-style port at byte address 8*i. The
// user must write them while the block is idle; the block does not enforce
// it. Reset frees the entry, empties both registers, loads register defaults.
// ----------------------------------------------------------------------------
`include "arp_single_entry_resolver_defines.svh"

module arp_single_entry_resolver
   import arpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;
   logic [15:0] valid_ticks_ff;
   logic [15:0] pending_ticks_ff;
   logic [7:0]  max_retries_ff;

   logic            in_valid_ff;
   req_type         in_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_data_in;

   entry_state_type entry_state_ff, entry_state_in;
   logic [31:0]     entry_ip_ff, entry_ip_in;
   logic [47:0]     entry_mac_ff, entry_mac_in;
   logic [15:0]     ticks_left_ff, ticks_left_in;
   logic [7:0]      retries_left_ff, retries_left_in;

   logic        res_ready;
   logic        fire;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic        hdr_ok;

   logic        in_stalled;
   logic        rsp_idle;
   logic        idle_fields_zero;
   logic        rsp_hit;
   logic        hit_fields_ok;

   assign res_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && res_ready;
   assign req_ready = !in_valid_ff || res_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff       <= '0;
         own_ip_ff        <= '0;
         valid_ticks_ff   <= VALID_TICKS_RST;
         pending_ticks_ff <= PENDING_TICKS_RST;
         max_retries_ff   <= MAX_RETRIES_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_OWN_MAC: begin
               own_mac_ff <= pwdata[47:0];
            end
            REG_OWN_IP: begin
               own_ip_ff <= pwdata[31:0];
            end
            REG_VALID_TICKS: begin
               valid_ticks_ff <= pwdata[15:0];
            end
            REG_PENDING_TICKS: begin
               pending_ticks_ff <= pwdata[15:0];
            end
            REG_MAX_RETRIES: begin
               max_retries_ff <= pwdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_OWN_MAC:       prdata = {16'd0, own_mac_ff};
         REG_OWN_IP:        prdata = {32'd0, own_ip_ff};
         REG_VALID_TICKS:   prdata = {48'd0, valid_ticks_ff};
         REG_PENDING_TICKS: prdata = {48'd0, pending_ticks_ff};
         REG_MAX_RETRIES:   prdata = {56'd0, max_retries_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      hdr_ok = in_data_ff.frame_long_enough
         && (in_data_ff.hw_type == HW_TYPE_ETH)
         && (in_data_ff.proto_type == PROTO_IPV4)
         && (in_data_ff.hw_len == HW_LEN_ETH)
         && (in_data_ff.proto_len == PROTO_LEN_IPV4)
         && (in_data_ff.arp_op inside {ARP_OP_REQUEST, ARP_OP_REPLY})
         && (in_data_ff.tgt_ip == own_ip_ff);
   end

   always_comb begin
      entry_state_in  = entry_state_ff;
      entry_ip_in     = entry_ip_ff;
      entry_mac_in    = entry_mac_ff;
      ticks_left_in   = ticks_left_ff;
      retries_left_in = retries_left_ff;
      rsp_data_in     = '0;
      case (in_data_ff.opcode)
         OP_TICK: begin
            if (entry_state_ff inside {ENTRY_VALID, ENTRY_PENDING}) begin
               ticks_left_in = ticks_left_ff - 16'd1;
               if (ticks_left_ff <= 16'd1) begin
                  if (entry_state_ff == ENTRY_VALID) begin
                     rsp_data_in.send_valid = 1'b1;
                     rsp_data_in.dest_mac   = BCAST_MAC;
                     rsp_data_in.out_tgt_ip = entry_ip_ff;
                     entry_state_in         = ENTRY_PENDING;
                     ticks_left_in          = pending_ticks_ff;
                  end else if (retries_left_ff == 8'd0) begin
                     entry_state_in = ENTRY_FREE;
                     ticks_left_in  = '0;
                  end else begin
                     retries_left_in        = retries_left_ff - 8'd1;
                     rsp_data_in.send_valid = 1'b1;
                     rsp_data_in.dest_mac   = BCAST_MAC;
                     rsp_data_in.out_tgt_ip = entry_ip_ff;
                     ticks_left_in          = pending_ticks_ff;
                  end
               end
            end
         end
         OP_RX: begin
            if (hdr_ok) begin
               if (in_data_ff.arp_op == ARP_OP_REQUEST) begin
                  rsp_data_in.send_valid     = 1'b1;
                  rsp_data_in.send_is_reply  = 1'b1;
                  rsp_data_in.dest_mac       = in_data_ff.sender_mac;
                  rsp_data_in.out_target_mac = in_data_ff.sender_mac;
                  rsp_data_in.out_tgt_ip     = in_data_ff.sender_ip;
               end
               entry_state_in  = ENTRY_VALID;
               entry_ip_in     = in_data_ff.sender_ip;
               entry_mac_in    = in_data_ff.sender_mac;
               ticks_left_in   = valid_ticks_ff;
               retries_left_in = max_retries_ff;
            end
         end
         OP_RESOLVE: begin
            if (entry_state_ff == ENTRY_VALID && entry_ip_ff == in_data_ff.query_ip) begin
               rsp_data_in.resolve_hit  = 1'b1;
               rsp_data_in.resolved_mac = entry_mac_ff;
            end else begin
               rsp_data_in.send_valid = 1'b1;
               rsp_data_in.dest_mac   = BCAST_MAC;
               rsp_data_in.out_tgt_ip = in_data_ff.query_ip;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.entry_status = entry_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_state_ff  <= ENTRY_FREE;
         entry_ip_ff     <= '0;
         entry_mac_ff    <= '0;
         ticks_left_ff   <= '0;
         retries_left_ff <= '0;
      end else if (fire) begin
         entry_state_ff  <= entry_state_in;
         entry_ip_ff     <= entry_ip_in;
         entry_mac_ff    <= entry_mac_in;
         ticks_left_ff   <= ticks_left_in;
         retries_left_ff <= retries_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign in_stalled       = in_valid_ff && !res_ready;
   assign rsp_idle         = rsp_valid_ff && !rsp_data_ff.send_valid;
   assign idle_fields_zero = !rsp_data_ff.send_is_reply && (rsp_data_ff.dest_mac == 48'd0)
      && (rsp_data_ff.out_tgt_ip == 32'd0);
   assign rsp_hit          = rsp_valid_ff && rsp_data_ff.resolve_hit;
   assign hit_fields_ok    = !rsp_data_ff.send_valid
      && (rsp_data_ff.entry_status == ENTRY_VALID);

   `ARPR_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, rsp_valid_ff)
   `ARPR_ASSERT_NEXT(a_stall_hold, clock, reset, in_stalled, in_valid_ff && $stable(in_data_ff))
   `ARPR_ASSERT_NOW(a_idle_send_clear, clock, reset, rsp_idle, idle_fields_zero)
   `ARPR_ASSERT_NOW(a_hit_is_valid, clock, reset, rsp_hit, hit_fields_ok)

endmodule
